// ===== design/slcet_pkg.sv =====
`default_nettype none

package slcet_pkg;

  // Frame geometry.
  localparam int LINES_PER_FRAME = 154;
  localparam int CYCLES_PER_LINE = 456;
  localparam int FRAME_CYCLES    = LINES_PER_FRAME * CYCLES_PER_LINE;

  // Field widths.
  localparam int TIME_W     = 32;
  localparam int LINE_NUM_W = 8;
  localparam int VC_W       = 17;
  localparam int LC_W       = 9;
  localparam int FC_W       = 17;

  // Widths of derived lengths; each gains one bit when doubled.
  localparam int CPL_W   = $clog2(CYCLES_PER_LINE + 1);
  localparam int LLEN_W  = CPL_W + 1;
  localparam int FRAME_W = $clog2(FRAME_CYCLES + 1);
  localparam int FLEN_W  = FRAME_W + 1;
  localparam int OFFS_W  = ((FRAME_W > FC_W) ? FRAME_W : FC_W) + 2;

  // Reciprocal of the line length, scaled by 2^32 and rounded up. For offsets
  // below 2^17 the scaled product gives the exact quotient.
  localparam int                RECIP_SH   = 32;
  localparam longint unsigned   LINE_RECIP =
    ((64'd1 << RECIP_SH) + CYCLES_PER_LINE - 1) / CYCLES_PER_LINE;
  localparam int                RECIP_W    = $clog2(LINE_RECIP + 1);

  // Item kinds.
  typedef enum logic [1:0] {
    FUNC_ADVANCE     = 2'd0,
    FUNC_RESET       = 2'd1,
    FUNC_LINE_QUERY  = 2'd2,
    FUNC_FRAME_QUERY = 2'd3
  } func_t;

endpackage

`default_nettype wire

// ===== design/scanline_counter_event_timer_core.sv =====
`default_nettype none

// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid/in_ready   | func, video_cycles, last_update,
//         |           |                     | line_cycle, frame_cycle, now_cycle
// out     | output    | out_valid/out_ready | line_number, line_end_time,
//         |           |                     | predicted_cycle
// cfg     | input     | cfg_we (no wait)    | cfg_wdata = double_speed
//
// One beat is accepted per cycle while the output is not stalled. The reset
// offset is divided by the line length on its way into the input register, and
// the state update and result are formed from that register into the result register.
// rst_n is synchronous and active low; it clears the line count, sets the line
// end time to one line length and clears double speed.
// A stalled output holds its result; the input register keeps taking beats
// until both stages are full.

module scanline_counter_event_timer_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // Input channel
  input  wire logic                           in_valid,
  output      logic                           in_ready,
  input  wire logic [1:0]                     in_func,
  input  wire logic [slcet_pkg::VC_W-1:0]     in_video_cycles,
  input  wire logic [slcet_pkg::TIME_W-1:0]   in_last_update,
  input  wire logic [slcet_pkg::LC_W-1:0]     in_line_cycle,
  input  wire logic [slcet_pkg::FC_W-1:0]     in_frame_cycle,
  input  wire logic [slcet_pkg::TIME_W-1:0]   in_now_cycle,
  // Result channel
  output      logic                           out_valid,
  input  wire logic                           out_ready,
  output      logic [slcet_pkg::LINE_NUM_W-1:0] out_line_number,
  output      logic [slcet_pkg::TIME_W-1:0]   out_line_end_time,
  output      logic [slcet_pkg::TIME_W-1:0]   out_predicted_cycle,
  // Configuration
  input  wire logic                           cfg_we,
  input  wire logic                           cfg_wdata
);

  // Input stage registers.
  logic                                 s1_valid_r;
  slcet_pkg::func_t                     s1_func_r;
  logic [slcet_pkg::VC_W-1:0]           s1_v_r;
  logic [slcet_pkg::LINE_NUM_W-1:0]     s1_quot_r;
  logic [slcet_pkg::TIME_W-1:0]         s1_last_r;
  logic [slcet_pkg::LC_W-1:0]           s1_lc_r;
  logic [slcet_pkg::FC_W-1:0]           s1_fc_r;
  logic [slcet_pkg::TIME_W-1:0]         s1_now_r;

  // Result registers.
  logic                                 out_valid_r;
  logic [slcet_pkg::LINE_NUM_W-1:0]     out_line_number_r;
  logic [slcet_pkg::TIME_W-1:0]         out_line_end_time_r;
  logic [slcet_pkg::TIME_W-1:0]         out_predicted_cycle_r;

  // Block state.
  logic                                 ds_r;
  logic [slcet_pkg::LINE_NUM_W-1:0]     line_cnt_r, line_cnt_nxt;
  logic [slcet_pkg::TIME_W-1:0]         line_end_r, line_end_nxt;
  logic [slcet_pkg::TIME_W-1:0]         pred_nxt;

  // Handshake.
  logic out_adv;
  logic s1_move;
  logic in_take;

  assign out_adv  = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;
  assign in_take  = in_valid && in_ready;

  // Reset offset: fold into one frame, then divide by the line length with a
  // scaled reciprocal. A single subtract suffices since 2^17 < 2 frames.
  logic [slcet_pkg::VC_W-1:0]                     vc_fold;
  logic [slcet_pkg::VC_W+slcet_pkg::RECIP_W-1:0]  quot_prod;

  always_comb begin
    if (in_video_cycles >= slcet_pkg::VC_W'(slcet_pkg::FRAME_CYCLES)) begin
      vc_fold = in_video_cycles - slcet_pkg::VC_W'(slcet_pkg::FRAME_CYCLES);
    end else begin
      vc_fold = in_video_cycles;
    end
    quot_prod = (slcet_pkg::VC_W+slcet_pkg::RECIP_W)'(vc_fold)
              * (slcet_pkg::VC_W+slcet_pkg::RECIP_W)'(slcet_pkg::LINE_RECIP);
  end

  // Lengths at the current speed.
  logic [slcet_pkg::LLEN_W-1:0] line_len;
  logic [slcet_pkg::FLEN_W-1:0] frame_len;

  assign line_len  = ds_r ? {slcet_pkg::CPL_W'(slcet_pkg::CYCLES_PER_LINE), 1'b0}
                          : {1'b0, slcet_pkg::CPL_W'(slcet_pkg::CYCLES_PER_LINE)};
  assign frame_len = ds_r ? {slcet_pkg::FRAME_W'(slcet_pkg::FRAME_CYCLES), 1'b0}
                          : {1'b0, slcet_pkg::FRAME_W'(slcet_pkg::FRAME_CYCLES)};

  // Item processing on the registered beat.
  logic [slcet_pkg::LINE_NUM_W:0]       cnt_inc;
  logic [slcet_pkg::CPL_W-1:0]          rem;
  logic [slcet_pkg::CPL_W-1:0]          to_end;
  logic [slcet_pkg::LLEN_W-1:0]         to_end_sc;
  logic [slcet_pkg::LC_W:0]             lc_sc;
  logic [slcet_pkg::LINE_NUM_W-1:0]     ln_sat;
  logic [slcet_pkg::LINE_NUM_W-1:0]     lines_left;
  logic [slcet_pkg::FRAME_W-1:0]        rest;
  logic [slcet_pkg::OFFS_W-2:0]         frame_off;
  logic [slcet_pkg::OFFS_W-1:0]         frame_off_sc;
  logic [slcet_pkg::TIME_W-1:0]         t_line, t_frame;
  logic [slcet_pkg::TIME_W-1:0]         d_line, d_frame;

  always_comb begin
    // Advance.
    cnt_inc = {1'b0, line_cnt_r} + (slcet_pkg::LINE_NUM_W+1)'(1);

    // Reset: remainder of the offset within its line.
    rem       = slcet_pkg::CPL_W'(s1_v_r - slcet_pkg::VC_W'(
                  32'(s1_quot_r) * slcet_pkg::CYCLES_PER_LINE));
    to_end    = slcet_pkg::CPL_W'(slcet_pkg::CYCLES_PER_LINE) - rem;
    to_end_sc = ds_r ? {to_end, 1'b0} : {1'b0, to_end};

    // Line query.
    lc_sc  = ds_r ? {s1_lc_r, 1'b0} : {1'b0, s1_lc_r};
    t_line = line_end_r + slcet_pkg::TIME_W'(lc_sc);
    d_line = t_line - s1_now_r;

    // Frame query; an out-of-range count counts as the last line.
    if (line_cnt_r >= slcet_pkg::LINE_NUM_W'(slcet_pkg::LINES_PER_FRAME)) begin
      ln_sat = slcet_pkg::LINE_NUM_W'(slcet_pkg::LINES_PER_FRAME - 1);
    end else begin
      ln_sat = line_cnt_r;
    end
    lines_left   = slcet_pkg::LINE_NUM_W'(slcet_pkg::LINES_PER_FRAME - 1) - ln_sat;
    rest         = slcet_pkg::FRAME_W'(32'(lines_left) * slcet_pkg::CYCLES_PER_LINE);
    frame_off    = (slcet_pkg::OFFS_W-1)'(rest) + (slcet_pkg::OFFS_W-1)'(s1_fc_r);
    frame_off_sc = ds_r ? {frame_off, 1'b0} : {1'b0, frame_off};
    t_frame      = line_end_r + slcet_pkg::TIME_W'(frame_off_sc);
    d_frame      = t_frame - s1_now_r;

    line_cnt_nxt = line_cnt_r;
    line_end_nxt = line_end_r;
    pred_nxt     = '0;

    case (s1_func_r)
      slcet_pkg::FUNC_ADVANCE: begin
        if (cnt_inc >= (slcet_pkg::LINE_NUM_W+1)'(slcet_pkg::LINES_PER_FRAME)) begin
          line_cnt_nxt = '0;
        end else begin
          line_cnt_nxt = cnt_inc[slcet_pkg::LINE_NUM_W-1:0];
        end
        line_end_nxt = line_end_r + slcet_pkg::TIME_W'(line_len);
      end
      slcet_pkg::FUNC_RESET: begin
        line_cnt_nxt = s1_quot_r;
        line_end_nxt = s1_last_r + slcet_pkg::TIME_W'(to_end_sc);
      end
      slcet_pkg::FUNC_LINE_QUERY: begin
        if (d_line > slcet_pkg::TIME_W'(line_len)) begin
          pred_nxt = t_line - slcet_pkg::TIME_W'(line_len);
        end else begin
          pred_nxt = t_line;
        end
      end
      slcet_pkg::FUNC_FRAME_QUERY: begin
        if (d_frame > slcet_pkg::TIME_W'(frame_len)) begin
          pred_nxt = t_frame - slcet_pkg::TIME_W'(frame_len);
        end else begin
          pred_nxt = t_frame;
        end
      end
      default: begin
        pred_nxt = '0;
      end
    endcase
  end

  // Control and state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ds_r        <= 1'b0;
      line_cnt_r  <= '0;
      line_end_r  <= slcet_pkg::TIME_W'(slcet_pkg::CYCLES_PER_LINE);
    end else begin
      if (cfg_we) begin
        ds_r <= cfg_wdata;
      end
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      if (s1_move) begin
        line_cnt_r <= line_cnt_nxt;
        line_end_r <= line_end_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= slcet_pkg::func_t'(in_func);
      s1_v_r    <= vc_fold;
      s1_quot_r <= quot_prod[slcet_pkg::RECIP_SH +: slcet_pkg::LINE_NUM_W];
      s1_last_r <= in_last_update;
      s1_lc_r   <= in_line_cycle;
      s1_fc_r   <= in_frame_cycle;
      s1_now_r  <= in_now_cycle;
    end
    if (s1_move) begin
      out_line_number_r     <= line_cnt_nxt;
      out_line_end_time_r   <= line_end_nxt;
      out_predicted_cycle_r <= pred_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_line_number     = out_line_number_r;
  assign out_line_end_time   = out_line_end_time_r;
  assign out_predicted_cycle = out_predicted_cycle_r;

  // The line count never leaves the frame.
  assert property (@(posedge clk) disable iff (!rst_n)
    line_cnt_r < slcet_pkg::LINE_NUM_W'(slcet_pkg::LINES_PER_FRAME))
    else $error("line count out of range");

  // A waiting result always shows the current state.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_line_number_r == line_cnt_r) && (out_line_end_time_r == line_end_r))
    else $error("result does not match state");

  // Advance and reset beats carry no prediction.
  assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && (s1_func_r == slcet_pkg::FUNC_ADVANCE || s1_func_r == slcet_pkg::FUNC_RESET))
    |=> out_predicted_cycle_r == '0)
    else $error("nonzero prediction on update beat");

  // The input side stalls only when both stages hold a beat.
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with free stage");

endmodule

`default_nettype wire
